[rtl/per_column_quality_histogram_stats_macros.svh]
// assertion macros
`ifndef PER_COLUMN_QUALITY_HISTOGRAM_STATS_MACROS_SVH
`define PER_COLUMN_QUALITY_HISTOGRAM_STATS_MACROS_SVH
`ifndef SYNTHESIS
`define PCQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PCQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PCQ_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define PCQ_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

[rtl/pcqhs_pkg.sv]
package pcqhs_pkg;
	localparam int CNT_W = 48;
	localparam int SUM_W = 57;
	localparam int CLASSES = 6;
	localparam logic [1:0] REG_QOFS = 2'd0;
	localparam logic [1:0] REG_MINQ = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;
	localparam logic signed [7:0] EMPTY_MIN = 8'sd100;
	localparam logic signed [7:0] EMPTY_MAX = -8'sd100;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_Q_RD, ST_Q_WALK, ST_Q_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic [6:0] quality_offset;
		logic signed [6:0] bin0_qual;
		logic fastq_mode;
	} cfg_t;

	function automatic logic [2:0] decode_base(input logic [7:0] ch);
		logic [2:0] r;
		r = 3'd0;
		case (ch)
			8'h41, 8'h61: r = 3'd1;
			8'h43, 8'h63: r = 3'd2;
			8'h47, 8'h67: r = 3'd3;
			8'h54, 8'h74: r = 3'd4;
			8'h4E, 8'h6E: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [7:0] sat8(input logic signed [10:0] v);
		logic signed [7:0] r;
		if (v > 11'sd127) r = 8'sd127;
		else if (v < -11'sd128) r = -8'sd128;
		else r = v[7:0];
		return r;
	endfunction
endpackage

[rtl/pcqhs_cfg.sv]
module pcqhs_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output pcqhs_pkg::cfg_t cfg
);
	pcqhs_pkg::cfg_t cfg_q;
	logic [1:0] idx;
	assign idx = paddr[3:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quality_offset <= 7'd33;
			cfg_q.bin0_qual <= 7'sd0;
			cfg_q.fastq_mode <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (idx)
				pcqhs_pkg::REG_QOFS: cfg_q.quality_offset <= pwdata[6:0];
				pcqhs_pkg::REG_MINQ: cfg_q.bin0_qual <= pwdata[6:0];
				pcqhs_pkg::REG_MODE: cfg_q.fastq_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pcqhs_pkg::REG_QOFS: prdata = {25'd0, cfg_q.quality_offset};
			pcqhs_pkg::REG_MINQ: prdata = {25'd0, cfg_q.bin0_qual};
			pcqhs_pkg::REG_MODE: prdata = {31'd0, cfg_q.fastq_mode};
			default: prdata = 32'd0;
		endcase
	end
endmodule

[rtl/per_column_quality_histogram_stats.sv]
// chan | dir | handshake           | fields
// in   | in  | valid / ready       | func column base_char quality_char weight class_select
// out  | out | out_valid/out_ready | total_count .. high_whisker
// cfg  | in  | APB, pready high    | quality_offset bin0_qual fastq_mode
// After reset a clear pass runs over the whole histogram memory, clearing the
// COLUMNS*6 slot records of the slot memory on its way; no word taken.
// Update: accept, then a read and a write per touched class.
// Query: accept, slot read, 3 histogram walks over QUALITY_BINS bins (none for bad
// column/class), finish; paced by the single hist read port and shared add/compare.
// A result waits in the output register until taken; no new word until then.
`include "per_column_quality_histogram_stats_macros.svh"
module per_column_quality_histogram_stats #(
	parameter int COLUMNS = 256,
	parameter int QUALITY_BINS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic func,
	input logic [7:0] column,
	input logic [7:0] base_char,
	input logic [7:0] quality_char,
	input logic [31:0] weight,
	input logic [2:0] class_select,
	output logic out_valid,
	input logic out_ready,
	output logic [47:0] total_count,
	output logic signed [7:0] min_qual_seen,
	output logic signed [7:0] max_qual_seen,
	output logic signed [56:0] quality_sum,
	output logic signed [7:0] first_quartile,
	output logic signed [7:0] median_qual,
	output logic signed [7:0] third_quartile,
	output logic [7:0] inter_quartile,
	output logic signed [7:0] low_whisker,
	output logic signed [7:0] high_whisker,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int SLOTS = COLUMNS * pcqhs_pkg::CLASSES;
	localparam int SL_W = $clog2(SLOTS);
	localparam int BIN_W = (QUALITY_BINS > 1) ? $clog2(QUALITY_BINS) : 1;
	localparam int HA_W = $clog2(SLOTS * QUALITY_BINS);
	localparam int CNT_W = pcqhs_pkg::CNT_W;
	localparam int SUM_W = pcqhs_pkg::SUM_W;
	localparam int SR_W = CNT_W + 16 + SUM_W;
	localparam logic [CNT_W-1:0] CMAX = {CNT_W{1'b1}};

	pcqhs_pkg::cfg_t cfg;
	pcqhs_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// memories
	logic [CNT_W-1:0] hist_mem [SLOTS*QUALITY_BINS];
	logic [SR_W-1:0] slot_mem [SLOTS];
	logic [CNT_W-1:0] hist_rd_q;
	logic [SR_W-1:0] slot_rd_q;
	logic hist_we, slot_we;
	logic [HA_W-1:0] hist_ra, hist_wa;
	logic [SL_W-1:0] slot_ra, slot_wa;
	logic [CNT_W-1:0] hist_wd;
	logic [SR_W-1:0] slot_wd;

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_wa] <= hist_wd;
		hist_rd_q <= hist_mem[hist_ra];
	end
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
	end

	pcqhs_pkg::state_t st_q, st_nx;
	logic [HA_W:0] clr_q;
	logic [SL_W-1:0] slot_q;
	logic [2:0] cls_q;
	logic second_q;
	logic bad_q;
	logic signed [7:0] qv_q;
	logic [BIN_W-1:0] bin_q;
	logic [31:0] w_q;
	logic [BIN_W:0] pos_q;
	logic [1:0] rk_q;
	logic [CNT_W-1:0] cum_q, rank_q;
	logic found_q;
	logic signed [7:0] qres_q [3];
	logic [CNT_W-1:0] cnt_q;
	logic signed [7:0] mn_q, mx_q;
	logic signed [SUM_W-1:0] sum_q;
	logic outv_q;
	logic signed [7:0] ow_lo_q, ow_hi_q;
	logic [7:0] oiqr_q;

	// slot record fields
	logic [CNT_W-1:0] r_cnt;
	logic signed [7:0] r_mn, r_mx;
	logic signed [SUM_W-1:0] r_sum;
	assign r_cnt = slot_rd_q[SR_W-1 -: CNT_W];
	assign r_mn = slot_rd_q[SUM_W+15 -: 8];
	assign r_mx = slot_rd_q[SUM_W+7 -: 8];
	assign r_sum = slot_rd_q[SUM_W-1:0];

	// quality decode
	logic signed [9:0] qraw, qlo, qhi, qc;
	always_comb begin
		qraw = $signed({2'b00, quality_char}) - $signed({3'b000, cfg.quality_offset});
		qlo = 10'(cfg.bin0_qual);
		qhi = qlo + 10'(QUALITY_BINS - 1);
		qc = qraw;
		if (qc < qlo) qc = qlo;
		if (qc > qhi) qc = qhi;
	end

	logic col_ok;
	assign col_ok = (32'(column) < 32'(COLUMNS));
	logic [SL_W-1:0] base_slot;
	assign base_slot = SL_W'(32'(column) * pcqhs_pkg::CLASSES);

	// update arithmetic (one shared multiply-add path)
	logic [CNT_W:0] cnt_add;
	logic signed [SUM_W+1:0] sum_add;
	logic [CNT_W:0] hb_add;
	logic [CNT_W-1:0] n_cnt, n_hb;
	logic signed [SUM_W-1:0] n_sum;
	logic signed [7:0] n_mn, n_mx;
	logic signed [41:0] prod;
	always_comb begin
		cnt_add = {1'b0, r_cnt} + (CNT_W+1)'(w_q);
		n_cnt = cnt_add[CNT_W] ? CMAX : cnt_add[CNT_W-1:0];
		prod = $signed(qv_q) * $signed({1'b0, w_q});
		sum_add = (SUM_W+2)'(r_sum) + (SUM_W+2)'(prod);
		if (sum_add > $signed((SUM_W+2)'({1'b0, {(SUM_W-1){1'b1}}})))
			n_sum = {1'b0, {(SUM_W-1){1'b1}}};
		else if (sum_add < -$signed((SUM_W+2)'({1'b0, {(SUM_W-1){1'b1}}})) - 1)
			n_sum = {1'b1, {(SUM_W-1){1'b0}}};
		else n_sum = sum_add[SUM_W-1:0];
		hb_add = {1'b0, hist_rd_q} + (CNT_W+1)'(w_q);
		n_hb = hb_add[CNT_W] ? CMAX : hb_add[CNT_W-1:0];
		n_mn = (qv_q < r_mn) ? qv_q : r_mn;
		n_mx = (qv_q > r_mx) ? qv_q : r_mx;
	end

	// walk
	logic [CNT_W:0] cum_nx;
	logic [CNT_W+1:0] cnt3;
	logic [CNT_W-1:0] rank_sel;
	logic signed [9:0] posq;
	assign cum_nx = {1'b0, cum_q} + {1'b0, hist_rd_q};
	assign posq = $signed({1'b0, 9'(pos_q)}) - 10'sd1 + 10'(cfg.bin0_qual);
	always_comb begin
		cnt3 = {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0};
		case (rk_q)
			2'd0: rank_sel = {2'b00, cnt_q[CNT_W-1:2]};
			2'd1: rank_sel = {1'b0, cnt_q[CNT_W-1:1]};
			default: rank_sel = cnt3[CNT_W+1:2];
		endcase
	end

	// whiskers
	logic signed [10:0] iqr, lw, hw, t32;
	always_comb begin
		iqr = 11'(qres_q[2]) - 11'(qres_q[0]);
		t32 = (iqr * 11'sd3) / 11'sd2;
		lw = 11'(qres_q[0]) - t32;
		hw = 11'(qres_q[2]) + t32;
		if (lw < 11'(mn_q)) lw = 11'(mn_q);
		if (hw > 11'(mx_q)) hw = 11'(mx_q);
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			pcqhs_pkg::ST_CLEAR: if (clr_q == (HA_W+1)'(SLOTS*QUALITY_BINS - 1))
				st_nx = pcqhs_pkg::ST_IDLE;
			pcqhs_pkg::ST_IDLE: if (valid) begin
				if (!func) st_nx = col_ok ? pcqhs_pkg::ST_UPD_RD : pcqhs_pkg::ST_IDLE;
				else st_nx = pcqhs_pkg::ST_Q_RD;
			end
			pcqhs_pkg::ST_UPD_RD: st_nx = pcqhs_pkg::ST_UPD_WR;
			pcqhs_pkg::ST_UPD_WR: st_nx = (second_q || cls_q == 3'd0) ?
				pcqhs_pkg::ST_IDLE : pcqhs_pkg::ST_UPD_RD;
			pcqhs_pkg::ST_Q_RD: st_nx = bad_q ? pcqhs_pkg::ST_Q_FIN : pcqhs_pkg::ST_Q_WALK;
			pcqhs_pkg::ST_Q_WALK:
				if (pos_q == (BIN_W+1)'(QUALITY_BINS) && rk_q == 2'd2)
					st_nx = pcqhs_pkg::ST_Q_FIN;
			pcqhs_pkg::ST_Q_FIN: st_nx = pcqhs_pkg::ST_OUT;
			pcqhs_pkg::ST_OUT: if (out_ready) st_nx = pcqhs_pkg::ST_IDLE;
			default: st_nx = pcqhs_pkg::ST_IDLE;
		endcase
	end

	logic [SL_W-1:0] cur_slot;
	assign cur_slot = second_q ? slot_q + SL_W'(cls_q) : slot_q;

	always_comb begin
		ready = (st_q == pcqhs_pkg::ST_IDLE);
		hist_we = 1'b0;
		slot_we = 1'b0;
		hist_wa = clr_q[HA_W-1:0];
		slot_wa = clr_q[SL_W-1:0];
		hist_wd = '0;
		slot_wd = {{CNT_W{1'b0}}, pcqhs_pkg::EMPTY_MIN, pcqhs_pkg::EMPTY_MAX, {SUM_W{1'b0}}};
		slot_ra = cur_slot;
		hist_ra = HA_W'({cur_slot, bin_q});
		case (st_q)
			pcqhs_pkg::ST_CLEAR: begin
				hist_we = 1'b1;
				slot_we = (clr_q < (HA_W+1)'(SLOTS));
			end
			pcqhs_pkg::ST_IDLE: begin
				slot_ra = (valid && func) ? base_slot + SL_W'(class_select) : base_slot;
			end
			pcqhs_pkg::ST_UPD_WR: begin
				slot_we = 1'b1;
				slot_wa = cur_slot;
				slot_wd = cfg.fastq_mode ? {n_cnt, n_mn, n_mx, n_sum} :
					{n_cnt, r_mn, r_mx, r_sum};
				hist_we = cfg.fastq_mode && (w_q != 32'd0);
				hist_wa = HA_W'(32'(cur_slot) * QUALITY_BINS + 32'(bin_q));
				hist_wd = n_hb;
			end
			default: ;
		endcase
		if (st_q == pcqhs_pkg::ST_UPD_RD)
			hist_ra = HA_W'(32'(cur_slot) * QUALITY_BINS + 32'(bin_q));
		if (st_q == pcqhs_pkg::ST_Q_RD || st_q == pcqhs_pkg::ST_Q_WALK)
			hist_ra = HA_W'(32'(slot_q) * QUALITY_BINS +
				32'((pos_q == (BIN_W+1)'(QUALITY_BINS)) ? '0 : pos_q[BIN_W-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pcqhs_pkg::ST_CLEAR;
			clr_q <= '0;
			outv_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == pcqhs_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == pcqhs_pkg::ST_Q_FIN) outv_q <= 1'b1;
			else if (out_ready) outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pcqhs_pkg::ST_IDLE: begin
				second_q <= 1'b0;
				qv_q <= pcqhs_pkg::sat8(11'(qc));
				bin_q <= BIN_W'(qc - qlo);
				w_q <= weight;
				cls_q <= pcqhs_pkg::decode_base(base_char);
				slot_q <= func ? base_slot + SL_W'(class_select) : base_slot;
				bad_q <= !col_ok || (class_select >= 3'd6);
				pos_q <= '0;
				rk_q <= 2'd0;
			end
			pcqhs_pkg::ST_UPD_WR: second_q <= 1'b1;
			pcqhs_pkg::ST_Q_RD: begin
				cnt_q <= bad_q ? '0 : r_cnt;
				mn_q <= bad_q ? pcqhs_pkg::EMPTY_MIN : r_mn;
				mx_q <= bad_q ? pcqhs_pkg::EMPTY_MAX : r_mx;
				sum_q <= bad_q ? '0 : r_sum;
				for (int i = 0; i < 3; i++) qres_q[i] <= pcqhs_pkg::EMPTY_MIN;
				pos_q <= (BIN_W+1)'(1);
				cum_q <= '0;
				found_q <= 1'b0;
			end
			pcqhs_pkg::ST_Q_WALK: begin
				if (pos_q == (BIN_W+1)'(QUALITY_BINS)) begin
					if (!found_q && !(rank_sel == '0) && !(cum_nx > {1'b0, rank_sel}))
						qres_q[rk_q] <= mx_q;
					else if (rank_sel == '0) qres_q[rk_q] <= mn_q;
					else if (!found_q)
						qres_q[rk_q] <= pcqhs_pkg::sat8(11'(posq));
					rk_q <= rk_q + 2'd1;
					pos_q <= (BIN_W+1)'(1);
					cum_q <= '0;
					found_q <= 1'b0;
				end else begin
					if (rank_sel == '0) begin
						qres_q[rk_q] <= mn_q;
						found_q <= 1'b1;
					end else if (!found_q && cum_nx > {1'b0, rank_sel}) begin
						qres_q[rk_q] <= pcqhs_pkg::sat8(11'(posq));
						found_q <= 1'b1;
					end
					cum_q <= cum_nx[CNT_W] ? CMAX : cum_nx[CNT_W-1:0];
					pos_q <= pos_q + 1'b1;
				end
			end
			pcqhs_pkg::ST_Q_FIN: begin
				oiqr_q <= iqr[7:0];
				ow_lo_q <= pcqhs_pkg::sat8(lw);
				ow_hi_q <= pcqhs_pkg::sat8(hw);
			end
			default: ;
		endcase
	end

	assign out_valid = outv_q;
	assign total_count = cnt_q;
	assign min_qual_seen = mn_q;
	assign max_qual_seen = mx_q;
	assign quality_sum = sum_q;
	assign first_quartile = qres_q[0];
	assign median_qual = qres_q[1];
	assign third_quartile = qres_q[2];
	assign inter_quartile = oiqr_q;
	assign low_whisker = ow_lo_q;
	assign high_whisker = ow_hi_q;

	`PCQ_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, !ready, "ready while result pending")
	`PCQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`PCQ_ASSERT_IMP(a_clr_idle, clk, arst_n, st_q == pcqhs_pkg::ST_CLEAR, !out_valid, "output in clear")
endmodule

[bench/tb_top.sv]
module tb_top;
	localparam int NCOL = 256;
	localparam int NBIN = 64;
	localparam int WDOG_LIMIT = 400000;

	typedef struct {
		bit func;
		bit [7:0] column;
		bit [7:0] base_char;
		bit [7:0] quality_char;
		bit [31:0] weight;
		bit [2:0] class_select;
	} word_t;

	typedef struct packed {
		bit [47:0] total_count;
		bit [7:0] min_q;
		bit [7:0] max_q;
		bit [56:0] qsum;
		bit [7:0] q1;
		bit [7:0] med;
		bit [7:0] q3;
		bit [7:0] iqr;
		bit [7:0] lw;
		bit [7:0] hw;
	} stats_t;

	class quality_stats_board;
		bit [47:0] hist[NCOL*pcqhs_pkg::CLASSES*NBIN];
		bit [47:0] counts[NCOL*pcqhs_pkg::CLASSES];
		int mins[NCOL*pcqhs_pkg::CLASSES];
		int maxs[NCOL*pcqhs_pkg::CLASSES];
		longint sums[NCOL*pcqhs_pkg::CLASSES];
		int qofs;
		int minq;
		bit fastq;
		stats_t pending_stats[$];
		int errors;
		int updates;
		int queries;
		int checked;

		function new();
			qofs = 33;
			minq = 0;
			fastq = 1;
			for (int i = 0; i < NCOL*pcqhs_pkg::CLASSES; i++) begin
				mins[i] = 100;
				maxs[i] = -100;
			end
		endfunction

		function int clampi(longint v, longint lo, longint hi);
			if (v < lo) return int'(lo);
			if (v > hi) return int'(hi);
			return int'(v);
		endfunction

		function int bin_class(bit [7:0] ch);
			case (ch)
				"A", "a": return 1;
				"C", "c": return 2;
				"G", "g": return 3;
				"T", "t": return 4;
				"N", "n": return 5;
				default: return 0;
			endcase
		endfunction

		function void add_to_slot(int slot, int q, int bin, longint w);
			longint c;
			longint s;
			longint h;
			c = longint'(counts[slot]) + w;
			counts[slot] = (c > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : c[47:0];
			if (!fastq)
				return;
			if (q < mins[slot])
				mins[slot] = q;
			if (q > maxs[slot])
				maxs[slot] = q;
			s = sums[slot] + longint'(q) * w;
			if (s > 64'sh00FFFFFFFFFFFFFF)
				s = 64'sh00FFFFFFFFFFFFFF;
			if (s < -64'sh0100000000000000)
				s = -64'sh0100000000000000;
			sums[slot] = s;
			h = longint'(hist[slot*NBIN + bin]) + w;
			hist[slot*NBIN + bin] = (h > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : h[47:0];
		endfunction

		function int quality_at_rank(int slot, longint unsigned rank);
			longint unsigned cum;
			cum = 0;
			if (rank == 0)
				return mins[slot];
			for (int p = 0; p < NBIN; p++) begin
				cum += hist[slot*NBIN + p];
				if (cum > rank)
					return clampi(p + minq, -128, 127);
			end
			return maxs[slot];
		endfunction

		function void note_word(word_t wd);
			int q;
			int bin;
			int slot;
			longint unsigned cnt;
			int mn, mx, q1, md, q3;
			longint sm, iqr, lw, hw;
			stats_t r;
			if (wd.func == 1'b0) begin
				updates++;
				q = clampi(int'(wd.quality_char) - qofs, minq, minq + NBIN - 1);
				q = clampi(q, -128, 127);
				bin = q - minq;
				if (bin >= NBIN)
					bin = NBIN - 1;
				slot = int'(wd.column) * pcqhs_pkg::CLASSES;
				add_to_slot(slot, q, bin, longint'(wd.weight));
				if (bin_class(wd.base_char) != 0)
					add_to_slot(slot + bin_class(wd.base_char), q, bin,
						longint'(wd.weight));
				return;
			end
			queries++;
			cnt = 0;
			mn = 100;
			mx = -100;
			q1 = 100;
			md = 100;
			q3 = 100;
			sm = 0;
			if (wd.class_select < pcqhs_pkg::CLASSES) begin
				slot = int'(wd.column) * pcqhs_pkg::CLASSES + int'(wd.class_select);
				cnt = counts[slot];
				mn = mins[slot];
				mx = maxs[slot];
				sm = sums[slot];
				q1 = quality_at_rank(slot, cnt / 4);
				md = quality_at_rank(slot, cnt / 2);
				q3 = quality_at_rank(slot, cnt * 3 / 4);
			end
			iqr = longint'(q3) - q1;
			lw = q1 - iqr * 3 / 2;
			hw = q3 + iqr * 3 / 2;
			if (lw < mn)
				lw = mn;
			if (hw > mx)
				hw = mx;
			r.total_count = cnt[47:0];
			r.min_q = mn[7:0];
			r.max_q = mx[7:0];
			r.qsum = sm[56:0];
			r.q1 = q1[7:0];
			r.med = md[7:0];
			r.q3 = q3[7:0];
			r.iqr = iqr[7:0];
			r.lw = 8'(clampi(lw, -128, 127));
			r.hw = 8'(clampi(hw, -128, 127));
			pending_stats.push_back(r);
		endfunction

		function void check_word(stats_t got);
			stats_t e;
			checked++;
			if (pending_stats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: count %0d", got.total_count);
				return;
			end
			e = pending_stats.pop_front();
			if (e != got) begin
				errors++;
				if (errors <= 10) begin
					$display("exp cnt %0d mn %0d mx %0d sum %0d q %0d %0d %0d i %0d w %0d %0d",
						e.total_count, $signed(e.min_q), $signed(e.max_q), $signed(e.qsum),
						$signed(e.q1), $signed(e.med), $signed(e.q3), e.iqr,
						$signed(e.lw), $signed(e.hw));
					$display("got cnt %0d mn %0d mx %0d sum %0d q %0d %0d %0d i %0d w %0d %0d",
						got.total_count, $signed(got.min_q), $signed(got.max_q),
						$signed(got.qsum), $signed(got.q1), $signed(got.med),
						$signed(got.q3), got.iqr, $signed(got.lw), $signed(got.hw));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic valid;
	logic ready;
	logic func;
	logic [7:0] column;
	logic [7:0] base_char;
	logic [7:0] quality_char;
	logic [31:0] weight;
	logic [2:0] class_select;
	logic out_valid;
	logic out_ready;
	logic [47:0] total_count;
	logic signed [7:0] min_qual_seen;
	logic signed [7:0] max_qual_seen;
	logic signed [56:0] quality_sum;
	logic signed [7:0] first_quartile;
	logic signed [7:0] median_qual;
	logic signed [7:0] third_quartile;
	logic [7:0] inter_quartile;
	logic signed [7:0] low_whisker;
	logic signed [7:0] high_whisker;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	quality_stats_board sb;
	bit hold_req;
	int wdog;
	int settings_run;

	per_column_quality_histogram_stats u_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .func(func),
		.column(column), .base_char(base_char), .quality_char(quality_char),
		.weight(weight), .class_select(class_select), .out_valid(out_valid),
		.out_ready(out_ready), .total_count(total_count), .min_qual_seen(min_qual_seen),
		.max_qual_seen(max_qual_seen), .quality_sum(quality_sum),
		.first_quartile(first_quartile), .median_qual(median_qual),
		.third_quartile(third_quartile), .inter_quartile(inter_quartile),
		.low_whisker(low_whisker), .high_whisker(high_whisker), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic word_t random_word();
		word_t wd;
		string bases;
		int r;
		bases = "ACGTNacgtn";
		wd.func = ($urandom_range(0, 99) < 75) ? 1'b0 : 1'b1;
		wd.column = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		wd.base_char = ($urandom_range(0, 9) < 8) ? bases[$urandom_range(0, 9)]
			: 8'($urandom);
		wd.quality_char = ($urandom_range(0, 9) < 7)
			? 8'(sb.qofs + $urandom_range(0, 70) - 5) : 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 60)
			wd.weight = $urandom_range(1, 5);
		else if (r < 90)
			wd.weight = $urandom_range(0, 1000);
		else if (r < 95)
			wd.weight = 0;
		else
			wd.weight = $urandom;
		wd.class_select = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 5))
			: 3'($urandom_range(6, 7));
		return wd;
	endfunction

	task automatic send_word(word_t wd);
		int g;
		g = pick_gap();
		if (g > 0) begin
			valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		valid <= 1'b1;
		func <= wd.func;
		column <= wd.column;
		base_char <= wd.base_char;
		quality_char <= wd.quality_char;
		weight <= wd.weight;
		class_select <= wd.class_select;
		do @(posedge clk); while (!ready);
		sb.note_word(wd);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pcqhs_pkg::REG_QOFS: sb.qofs = int'(val[6:0]);
			pcqhs_pkg::REG_MINQ: sb.minq = int'($signed(val[6:0]));
			default: sb.fastq = val[0];
		endcase
	endtask

	task automatic drain();
		valid <= 1'b0;
		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_mode(int qofs, int minq, bit mode);
		drain();
		reg_write(pcqhs_pkg::REG_QOFS, 32'(qofs));
		reg_write(pcqhs_pkg::REG_MINQ, 32'(minq) & 32'h7F);
		reg_write(pcqhs_pkg::REG_MODE, {31'd0, mode});
		settings_run++;
	endtask

	task automatic directed_words();
		word_t wd;
		bit [7:0] chars[8];
		chars = '{"A", "c", "G", "t", "N", "x", 8'h00, 8'hFF};
		for (int i = 0; i < 8; i++) begin
			wd.func = 1'b0;
			wd.column = 8'd0;
			wd.base_char = chars[i];
			wd.quality_char = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(40 + i * 5);
			wd.weight = (i == 2) ? 32'd0 : (i == 3) ? 32'hFFFFFFFF : 32'(i + 1);
			wd.class_select = 3'd0;
			send_word(wd);
		end
		wd.column = 8'd255;
		wd.base_char = "n";
		wd.quality_char = 8'd60;
		wd.weight = 32'd1;
		send_word(wd);
		for (int c = 0; c < 8; c++) begin
			wd.func = 1'b1;
			wd.column = 8'd0;
			wd.class_select = 3'(c);
			send_word(wd);
		end
		wd.column = 8'd255;
		wd.class_select = 3'd5;
		send_word(wd);
		wd.column = 8'd200;
		wd.class_select = 3'd0;
		send_word(wd);
	endtask

	task automatic random_words(int n);
		for (int i = 0; i < n; i++)
			send_word(random_word());
	endtask

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 50)
					repeat ($urandom_range(0, 20)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		stats_t got;
		if (arst_n && out_valid && out_ready) begin
			got.total_count = total_count;
			got.min_q = min_qual_seen;
			got.max_q = max_qual_seen;
			got.qsum = quality_sum;
			got.q1 = first_quartile;
			got.med = median_qual;
			got.q3 = third_quartile;
			got.iqr = inter_quartile;
			got.lw = low_whisker;
			got.hw = high_whisker;
			sb.check_word(got);
		end
	end

	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready) || psel)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		sb = new();
		wdog = 0;
		hold_req = 1'b0;
		settings_run = 1;
		arst_n = 1'b0;
		valid = 1'b0;
		func = 1'b0;
		column = '0;
		base_char = '0;
		quality_char = '0;
		weight = '0;
		class_select = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		hold_req = 1'b1;
		random_words(240);
		set_mode(0, -64, 1'b1);
		random_words(240);
		set_mode(127, 63, 1'b1);
		random_words(240);
		set_mode(64, -10, 1'b0);
		random_words(240);
		set_mode(33, 20, 1'b1);
		random_words(240);
		drain();
		$display("covered %0d updates and %0d queries over %0d register settings",
			sb.updates, sb.queries, settings_run);
		$display("%0d result words checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
